@@ design/belt_pkg.sv @@
// ----------------------------------------------------------------------------
// belt_pkg: shared constants and functions for the belt block cipher
// s-box h, the g_r function and the per-round word layout
// ----------------------------------------------------------------------------
package belt_pkg;

	localparam int unsigned KeyWords = 8;
	localparam int unsigned Rounds = 8;
	localparam int unsigned KeysPerRound = 7;
	localparam int unsigned WordW = 32;
	// one pipeline stage per g_r step
	localparam int unsigned StepsPerRound = 7;
	localparam int unsigned Stages = Rounds * StepsPerRound;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} blk_t;

	localparam logic [7:0] SboxH [256] = '{
		8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
		8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
		8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
		8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
		8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
		8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
		8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
		8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
		8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
		8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
		8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
		8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
		8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
		8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
		8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
		8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
	};

	function automatic word_t subst(input word_t x);
		word_t s;
		for (int i = 0; i < 4; i++) begin
			s[8*i +: 8] = SboxH[x[8*i +: 8]];
		end
		return s;
	endfunction

	function automatic word_t g5(input word_t x);
		word_t s;
		s = subst(x);
		return {s[26:0], s[31:27]};
	endfunction

	function automatic word_t g13(input word_t x);
		word_t s;
		s = subst(x);
		return {s[18:0], s[31:19]};
	endfunction

	function automatic word_t g21(input word_t x);
		word_t s;
		s = subst(x);
		return {s[10:0], s[31:11]};
	endfunction

endpackage

@@ design/belt_block_encrypt.sv @@
// ----------------------------------------------------------------------------
// belt_block_encrypt: pipelined belt block cipher encryption
// one g_r step per stage, 56 stages; if not halted, one block per cycle
// ----------------------------------------------------------------------------
// channel   | dir | content
// s_axis    | in  | plain_a..plain_d (128 bits)
// m_axis    | out | cipher_0..cipher_3 (128 bits)
// apb       | in  | key_word_0..key_word_7 at 4*i
//
// 56 step stages (one s-box g_r plus add each), the last of which drives the
// output; a block may enter every cycle while the pipeline is not halted.
// the whole pipeline advances together and halts while the last stage
// holds a result that is not taken; nothing is lost or repeated.
// reset clears the valid bits and the key registers.
module belt_block_encrypt (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // plain_a, plain_b, plain_c, plain_d
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // cipher_0, cipher_1, cipher_2, cipher_3
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int unsigned N = belt_pkg::Stages;

	belt_pkg::word_t key_q [belt_pkg::KeyWords];
	belt_pkg::blk_t  blk_in;
	belt_pkg::blk_t  blk_s [1:N];
	logic            vld_s [1:N];
	belt_pkg::blk_t  cur   [N];
	belt_pkg::blk_t  nxt   [N];
	logic            adv;

	assign pready = 1'b1;
	assign prdata = key_q[paddr[4:2]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < belt_pkg::KeyWords; i++) key_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			key_q[paddr[4:2]] <= pwdata;
		end
	end

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	assign blk_in = '{a: s_axis_tdata[31:0], b: s_axis_tdata[63:32],
		c: s_axis_tdata[95:64], d: s_axis_tdata[127:96]};

	// step j of round r uses key word (7*(r-1)+j) mod 8
	always_comb begin
		cur[0] = blk_in;
		for (int n = 1; n < N; n++) cur[n] = blk_s[n];
		for (int n = 0; n < N; n++) begin
			automatic int r = n / 7 + 1;
			automatic int j = n % 7;
			automatic belt_pkg::word_t k = key_q[(n) % 8];
			automatic belt_pkg::blk_t x = cur[n];
			automatic belt_pkg::word_t e;
			case (j)
				0: x.b = x.b ^ belt_pkg::g5(x.a + k);
				1: x.c = x.c ^ belt_pkg::g21(x.d + k);
				2: x.a = x.a - belt_pkg::g13(x.b + k);
				3: begin
					e = belt_pkg::g21(x.b + x.c + k) ^ 32'(r);
					x.b = x.b + e;
					x.c = x.c - e;
				end
				4: x.d = x.d + belt_pkg::g13(x.c + k);
				5: x.b = x.b ^ belt_pkg::g21(x.a + k);
				default: begin
					x.c = x.c ^ belt_pkg::g5(x.d + k);
					// a,b,c,d <- b,d,a,c
					x = '{a: x.b, b: x.d, c: x.a, d: x.c};
				end
			endcase
			nxt[n] = x;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 1; n <= N; n++) vld_s[n] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int n = 2; n <= N; n++) vld_s[n] <= vld_s[n-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int n = 1; n <= N; n++) blk_s[n] <= nxt[n-1];
		end
	end

	// ciphertext is b, d, a, c of the state after the last round
	assign m_axis_tvalid = vld_s[N];
	assign m_axis_tdata = {blk_s[N].c, blk_s[N].a, blk_s[N].d, blk_s[N].b};

endmodule

@@ design/belt_chk.sv @@
// ----------------------------------------------------------------------------
// belt_chk: port checker for belt_block_encrypt
// handshake and flow checks on the stream ports, pready on the apb ports
// ----------------------------------------------------------------------------
module belt_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic         pready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline halted");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind belt_block_encrypt belt_chk u_chk (.*);

@@ verif/belt_block_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// belt_block_checker: ciphertext scoreboard for belt_block_encrypt
// watches the apb writes and both streams, computes the expected ciphertext
// for every accepted plaintext block and compares it with the output stream
// ----------------------------------------------------------------------------
module belt_block_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	input  logic         pready,
	output int           fail_count,
	output int           pending
);

	localparam logic [7:0] HTab [256] = '{
		8'hB1,8'h94,8'hBA,8'hC8,8'h0A,8'h08,8'hF5,8'h3B,8'h36,8'h6D,8'h00,8'h8E,8'h58,8'h4A,8'h5D,8'hE4,
		8'h85,8'h04,8'hFA,8'h9D,8'h1B,8'hB6,8'hC7,8'hAC,8'h25,8'h2E,8'h72,8'hC2,8'h02,8'hFD,8'hCE,8'h0D,
		8'h5B,8'hE3,8'hD6,8'h12,8'h17,8'hB9,8'h61,8'h81,8'hFE,8'h67,8'h86,8'hAD,8'h71,8'h6B,8'h89,8'h0B,
		8'h5C,8'hB0,8'hC0,8'hFF,8'h33,8'hC3,8'h56,8'hB8,8'h35,8'hC4,8'h05,8'hAE,8'hD8,8'hE0,8'h7F,8'h99,
		8'hE1,8'h2B,8'hDC,8'h1A,8'hE2,8'h82,8'h57,8'hEC,8'h70,8'h3F,8'hCC,8'hF0,8'h95,8'hEE,8'h8D,8'hF1,
		8'hC1,8'hAB,8'h76,8'h38,8'h9F,8'hE6,8'h78,8'hCA,8'hF7,8'hC6,8'hF8,8'h60,8'hD5,8'hBB,8'h9C,8'h4F,
		8'hF3,8'h3C,8'h65,8'h7B,8'h63,8'h7C,8'h30,8'h6A,8'hDD,8'h4E,8'hA7,8'h79,8'h9E,8'hB2,8'h3D,8'h31,
		8'h3E,8'h98,8'hB5,8'h6E,8'h27,8'hD3,8'hBC,8'hCF,8'h59,8'h1E,8'h18,8'h1F,8'h4C,8'h5A,8'hB7,8'h93,
		8'hE9,8'hDE,8'hE7,8'h2C,8'h8F,8'h0C,8'h0F,8'hA6,8'h2D,8'hDB,8'h49,8'hF4,8'h6F,8'h73,8'h96,8'h47,
		8'h06,8'h07,8'h53,8'h16,8'hED,8'h24,8'h7A,8'h37,8'h39,8'hCB,8'hA3,8'h83,8'h03,8'hA9,8'h8B,8'hF6,
		8'h92,8'hBD,8'h9B,8'h1C,8'hE5,8'hD1,8'h41,8'h01,8'h54,8'h45,8'hFB,8'hC9,8'h5E,8'h4D,8'h0E,8'hF2,
		8'h68,8'h20,8'h80,8'hAA,8'h22,8'h7D,8'h64,8'h2F,8'h26,8'h87,8'hF9,8'h34,8'h90,8'h40,8'h55,8'h11,
		8'hBE,8'h32,8'h97,8'h13,8'h43,8'hFC,8'h9A,8'h48,8'hA0,8'h2A,8'h88,8'h5F,8'h19,8'h4B,8'h09,8'hA1,
		8'h7E,8'hCD,8'hA4,8'hD0,8'h15,8'h44,8'hAF,8'h8C,8'hA5,8'h84,8'h50,8'hBF,8'h66,8'hD2,8'hE8,8'h8A,
		8'hA2,8'hD7,8'h46,8'h52,8'h42,8'hA8,8'hDF,8'hB3,8'h69,8'h74,8'hC5,8'h51,8'hEB,8'h23,8'h29,8'h21,
		8'hD4,8'hEF,8'hD9,8'hB4,8'h3A,8'h62,8'h28,8'h75,8'h91,8'h14,8'h10,8'hEA,8'h77,8'h6C,8'hDA,8'h1D
	};

	belt_pkg::word_t key_shadow [belt_pkg::KeyWords];
	logic [127:0] cipher_q [$];

	function automatic belt_pkg::word_t sub_rot(input belt_pkg::word_t x, input int r);
		belt_pkg::word_t s;
		for (int i = 0; i < 4; i++) begin
			s[8*i +: 8] = HTab[x[8*i +: 8]];
		end
		return (s << r) | (s >> (32 - r));
	endfunction

	function automatic logic [127:0] encrypt_block(input logic [127:0] pt);
		belt_pkg::word_t a, b, c, d, e, t;
		int k;
		a = pt[31:0];
		b = pt[63:32];
		c = pt[95:64];
		d = pt[127:96];
		for (int i = 1; i <= belt_pkg::Rounds; i++) begin
			k = belt_pkg::KeysPerRound * (i - 1);
			b ^= sub_rot(a + key_shadow[k % 8], 5);
			c ^= sub_rot(d + key_shadow[(k + 1) % 8], 21);
			a -= sub_rot(b + key_shadow[(k + 2) % 8], 13);
			e = sub_rot(b + c + key_shadow[(k + 3) % 8], 21) ^ belt_pkg::word_t'(i);
			b += e;
			c -= e;
			d += sub_rot(c + key_shadow[(k + 4) % 8], 13);
			b ^= sub_rot(a + key_shadow[(k + 5) % 8], 21);
			c ^= sub_rot(d + key_shadow[(k + 6) % 8], 5);
			t = a; a = b; b = t;
			t = c; c = d; d = t;
			t = b; b = c; c = t;
		end
		return {c, a, d, b};
	endfunction

	assign pending = cipher_q.size();

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] exp_ct;
		int errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < belt_pkg::KeyWords; i++) key_shadow[i] = '0;
			cipher_q.delete();
			fail_count <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[4:2] < belt_pkg::KeyWords)
				key_shadow[paddr[4:2]] = pwdata;
			if (s_axis_tvalid && s_axis_tready)
				cipher_q.push_back(encrypt_block(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (cipher_q.size() == 0) begin
					$error("unexpected transaction %h", m_axis_tdata);
					errs = errs + 1;
				end else begin
					exp_ct = cipher_q.pop_front();
					for (int f = 0; f < 4; f++) begin
						if (exp_ct[32*f +: 32] !== m_axis_tdata[32*f +: 32]) begin
							$error("cipher_%0d expected %h actual %h", f,
								exp_ct[32*f +: 32], m_axis_tdata[32*f +: 32]);
							errs = errs + 1;
						end
					end
				end
			end
			if (errs != 0)
				fail_count <= fail_count + errs;
		end
	end
endmodule

@@ verif/belt_block_encrypt_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// belt_block_encrypt_tb: stimulus and verdict for belt_block_encrypt
// loads several keys over apb and streams plaintext blocks with random
// gaps and back-pressure; belt_block_checker scores the ciphertext
// ----------------------------------------------------------------------------
module belt_block_encrypt_tb;
	localparam int Latency = 56;
	localparam int WatchLimit = 5000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	int           fail_count;
	int           pending;
	int           idle_cycles = 0;
	bit           calm = 1'b0;
	bit           hold_sink = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	belt_block_encrypt dut (.*);

	belt_block_checker chk (.*);

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sink: random stall bursts, or a long hold-off on request
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				for (int i = 0; i < 300; i++) @(posedge clk);
				hold_sink = 1'b0;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 5);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic key_write(input int idx, input logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 5'(idx * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain;
		while (pending != 0) @(posedge clk);
	endtask

	// offers one block; random gap burst beforehand unless calm
	task automatic send_block(input logic [127:0] pt);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pt;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	function automatic logic [127:0] rand_block();
		logic [127:0] v;
		int mode;
		mode = $urandom_range(0, 9);
		for (int w = 0; w < 4; w++) v[32*w +: 32] = $urandom;
		if (mode == 0) v = '0;
		else if (mode == 1) v = '1;
		else if (mode == 2) v[32*$urandom_range(0, 3) +: 32] = '1;
		return v;
	endfunction

	task automatic load_key(input int kind);
		for (int i = 0; i < 8; i++) begin
			case (kind)
				0: key_write(i, 32'h0);
				1: key_write(i, 32'hFFFF_FFFF);
				2: key_write(i, (i % 2) ? 32'hAAAA_AAAA : 32'h5555_5555);
				default: key_write(i, $urandom);
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all-zero key straight after reset
		send_block('0);
		send_block('1);
		send_block({32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF});
		send_block({32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0});
		send_block(128'h0123_4567_89AB_CDEF_FEDC_BA98_7654_3210);
		s_axis_tvalid <= 1'b0;
		drain();
		repeat (Latency) @(posedge clk);

		for (int k = 1; k <= 2; k++) begin
			load_key(k);
			for (int j = 0; j < 8; j++) send_block(rand_block());
			s_axis_tvalid <= 1'b0;
			drain();
			repeat (Latency) @(posedge clk);
		end
		// an unaligned address lands on the key word it falls in
		psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'd31; pwdata <= $urandom;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);

		for (int phase = 0; phase < 6; phase++) begin
			load_key(phase == 5 ? 1 : 3);
			if (phase == 1) hold_sink = 1'b1;
			if (phase == 5) calm = 1'b1;
			for (int j = 0; j < 270; j++) begin
				send_block(rand_block());
				// sender pauses until the pipeline has emptied
				if (phase == 2 && j == 100) begin
					s_axis_tvalid <= 1'b0;
					drain();
				end
			end
			s_axis_tvalid <= 1'b0;
			drain();
			repeat (Latency) @(posedge clk);
		end

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

@@ belt_block_encrypt.f @@
design/belt_pkg.sv
design/belt_block_encrypt.sv
design/belt_chk.sv
verif/belt_block_checker.sv
verif/belt_block_encrypt_tb.sv
